>>> rtl/kwm_pkg.sv
// kwm_pkg: shared codes, field types and parameter defaults for the k-way merge block.
// Used by k_way_sorted_merge; depends on nothing else.
`timescale 1ns / 1ps

package kwm_pkg;

   localparam int NUM_SEQS_DEF  = 8;
   localparam int SEQ_DEPTH_DEF = 64;

   localparam int FUNC_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int SEQ_IDX_W = 3;
   localparam int VALUE_W   = 32;

   typedef logic [FUNC_W-1:0]           func_type;
   typedef logic [STATUS_W-1:0]         status_type;
   typedef logic [SEQ_IDX_W-1:0]        seq_type;
   typedef logic signed [VALUE_W-1:0]   value_type;

   // request function codes
   localparam func_type FUNC_LOAD  = 2'd0;
   localparam func_type FUNC_POP   = 2'd1;
   localparam func_type FUNC_CLEAR = 2'd2;

   // response status codes
   localparam status_type STAT_LOAD_OK = 2'd0;
   localparam status_type STAT_POPPED  = 2'd1;
   localparam status_type STAT_EMPTY   = 2'd2;
   localparam status_type STAT_DROPPED = 2'd3;

endpackage

>>> rtl/k_way_sorted_merge.sv
// k_way_sorted_merge: K-way merge of sorted signed sequences held in one element memory.
// Depends on kwm_pkg for codes, field types and parameter defaults.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_valid/req_ready): req_func selects load, pop or clear.
//   A load appends req_value to sequence req_seq_index; a pop returns the
//   smallest unread head over all sequences (ties go to the lowest index);
//   a clear empties every sequence. Every request transaction produces
//   exactly one response transaction on rsp_valid/rsp_ready.
//   Timing: requests are taken one at a time. Load, clear and unused codes
//   pass through decode, then the response register. A pop waits in the
//   tree state for the root, then refills the head of the winning sequence
//   unless it empties its sequence or finds every sequence empty, then
//   goes to the response register: the head registers feed a minimum tree
//   with one register per level, and the refill costs one read of the
//   element memory (registered read port).
//   Heads live in registers; elements behind each head live in the memory.
//   Reset clears all fill counts and read positions, so every sequence is
//   empty; the element memory itself is not cleared and needs no pass.
//   A stalled receiver holds the response register; the next request is
//   decoded but its response waits until the previous one is taken.
module k_way_sorted_merge #(
   parameter int NUM_SEQS  = kwm_pkg::NUM_SEQS_DEF,
   parameter int SEQ_DEPTH = kwm_pkg::SEQ_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  kwm_pkg::func_type   req_func,
   input  kwm_pkg::seq_type    req_seq_index,
   input  kwm_pkg::value_type  req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output kwm_pkg::status_type rsp_status,
   output kwm_pkg::value_type  rsp_merged_value,
   output kwm_pkg::seq_type    rsp_source_seq
);

   import kwm_pkg::*;

   localparam int SEQ_W    = $clog2(NUM_SEQS);
   localparam int NUM_LEAF = 1 << SEQ_W;
   localparam int TREE_LVL = SEQ_W;
   localparam int WCNT_W   = $clog2(TREE_LVL + 1);
   localparam int CNT_W    = $clog2(SEQ_DEPTH + 1);
   localparam int MEM_N    = NUM_SEQS * SEQ_DEPTH;
   localparam int AW       = $clog2(MEM_N);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TREE = 2'd1;
   localparam logic [1:0] ST_FILL = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [WCNT_W-1:0] wait_cnt_ff;

   // per-sequence bookkeeping; leaves past NUM_SEQS stay empty
   logic [CNT_W-1:0]  fill_ff  [NUM_LEAF];
   logic [CNT_W-1:0]  rdpos_ff [NUM_LEAF];
   value_type         head_ff  [NUM_LEAF];

   // minimum tree, heap numbered: node i takes children 2i and 2i+1
   logic              node_vld_ff [1:NUM_LEAF-1];
   value_type         node_val_ff [1:NUM_LEAF-1];
   logic [SEQ_W-1:0]  node_idx_ff [1:NUM_LEAF-1];
   logic              t_vld [1:2*NUM_LEAF-1];
   value_type         t_val [1:2*NUM_LEAF-1];
   logic [SEQ_W-1:0]  t_idx [1:2*NUM_LEAF-1];

   value_type         elem_mem_ff [MEM_N];
   value_type         mem_rdata_ff;

   status_type        res_status_ff;
   value_type         res_value_ff;
   seq_type           res_src_ff;
   logic [SEQ_W-1:0]  pop_idx_ff;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   value_type         rsp_value_ff;
   seq_type           rsp_src_ff;

   logic              accept;
   logic              seq_ok;
   logic [SEQ_W-1:0]  seq_sel;
   logic [SEQ_W-1:0]  win_idx;
   logic [SEQ_W-1:0]  fill_idx;
   logic [CNT_W-1:0]  fill_sel;
   logic [CNT_W-1:0]  rdpos_next;
   logic              load_ok;
   logic              decide;
   logic              has_next;
   logic              out_free;
   logic              mem_we;
   logic              mem_re;
   logic [AW-1:0]     mem_waddr;
   logic [AW-1:0]     mem_raddr;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // drop loads aimed past the last sequence
   assign seq_ok  = (32'(req_seq_index) < NUM_SEQS);
   assign seq_sel = SEQ_W'(req_seq_index);
   assign win_idx = node_idx_ff[1];

   // one read of the fill table: load sequence when idle, winner otherwise
   assign fill_idx   = (state_ff == ST_IDLE) ? seq_sel : win_idx;
   assign fill_sel   = fill_ff[fill_idx];
   assign rdpos_next = rdpos_ff[win_idx] + CNT_W'(1);
   assign load_ok    = seq_ok && (fill_sel != CNT_W'(SEQ_DEPTH));

   assign decide   = (state_ff == ST_TREE) && (wait_cnt_ff == WCNT_W'(TREE_LVL));
   assign has_next = (rdpos_next != fill_sel);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign mem_we    = accept && (req_func == FUNC_LOAD) && load_ok;
   assign mem_re    = decide && node_vld_ff[1] && has_next;
   assign mem_waddr = AW'(seq_sel) * AW'(SEQ_DEPTH) + AW'(fill_sel);
   assign mem_raddr = AW'(win_idx) * AW'(SEQ_DEPTH) + AW'(rdpos_next);

   // element memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         elem_mem_ff[mem_waddr] <= req_value;
      end
      if (mem_re) begin
         mem_rdata_ff <= elem_mem_ff[mem_raddr];
      end
   end

   // tree inputs: leaves are the head registers, inner nodes the tree registers
   always_comb begin
      for (int s = 0; s < NUM_LEAF; s++) begin
         t_vld[NUM_LEAF+s] = (rdpos_ff[s] != fill_ff[s]);
         t_val[NUM_LEAF+s] = head_ff[s];
         t_idx[NUM_LEAF+s] = SEQ_W'(s);
      end
      for (int i = 1; i < NUM_LEAF; i++) begin
         t_vld[i] = node_vld_ff[i];
         t_val[i] = node_val_ff[i];
         t_idx[i] = node_idx_ff[i];
      end
   end

   // one level per register; the right child wins only when strictly smaller
   always_ff @(posedge clock) begin
      for (int i = 1; i < NUM_LEAF; i++) begin
         if (t_vld[2*i+1] && (!t_vld[2*i] || (t_val[2*i+1] < t_val[2*i]))) begin
            node_vld_ff[i] <= 1'b1;
            node_val_ff[i] <= t_val[2*i+1];
            node_idx_ff[i] <= t_idx[2*i+1];
         end else begin
            node_vld_ff[i] <= t_vld[2*i];
            node_val_ff[i] <= t_val[2*i];
            node_idx_ff[i] <= t_idx[2*i];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_func == FUNC_POP) ? ST_TREE : ST_OUT;
            end
         end
         ST_TREE: begin
            if (decide) begin
               state_in = mem_re ? ST_FILL : ST_OUT;
            end
         end
         ST_FILL: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control: state, counters, response handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_LEAF; s++) begin
            fill_ff[s]  <= '0;
            rdpos_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         // raise valid with a fresh response, drop it once the receiver takes it
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               wait_cnt_ff <= '0;
               if (accept && (req_func == FUNC_LOAD) && load_ok) begin
                  fill_ff[seq_sel] <= fill_sel + CNT_W'(1);
               end
               if (accept && (req_func == FUNC_CLEAR)) begin
                  for (int s = 0; s < NUM_LEAF; s++) begin
                     fill_ff[s]  <= '0;
                     rdpos_ff[s] <= '0;
                  end
               end
            end
            ST_TREE: begin
               wait_cnt_ff <= wait_cnt_ff + WCNT_W'(1);
               if (decide && node_vld_ff[1]) begin
                  rdpos_ff[win_idx] <= rdpos_next;
               end
            end
            default: ;
         endcase
      end
   end

   // payload: result staging, head refresh, response register
   always_ff @(posedge clock) begin
      if (accept) begin
         res_value_ff <= '0;
         res_src_ff   <= '0;
         case (req_func)
            FUNC_LOAD:  res_status_ff <= load_ok ? STAT_LOAD_OK : STAT_DROPPED;
            FUNC_CLEAR: res_status_ff <= STAT_LOAD_OK;
            default:    res_status_ff <= STAT_EMPTY;
         endcase
         // a load into an empty sequence becomes its head at once
         if (mem_we && (rdpos_ff[seq_sel] == fill_sel)) begin
            head_ff[seq_sel] <= req_value;
         end
      end
      if (decide) begin
         pop_idx_ff <= win_idx;
         if (node_vld_ff[1]) begin
            res_status_ff <= STAT_POPPED;
            res_value_ff  <= node_val_ff[1];
            res_src_ff    <= SEQ_IDX_W'(win_idx);
         end
      end
      if (state_ff == ST_FILL) begin
         head_ff[pop_idx_ff] <= mem_rdata_ff;
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_src_ff    <= res_src_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_source_seq   = rsp_src_ff;

endmodule
